// ===== src/series_reciprocal_division_unit_macros.svh =====
// Assertion macros shared by the series reciprocal division unit
`ifndef SERIES_RECIPROCAL_DIVISION_UNIT_MACROS_SVH
`define SERIES_RECIPROCAL_DIVISION_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, quiet during reset
`define SRD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("srd: assertion failed");
// next-cycle implication
`define SRD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("srd: assertion failed");
`else
`define SRD_ASSERT_IMP(lbl, ante, cons)
`define SRD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/srd_pkg.sv =====
// Package: types, codes and constants of the series reciprocal division unit
`default_nettype none
package srd_pkg;

	localparam int MaxTerms = 16;
	localparam int TermW    = 5;

	localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_BU,
		ST_SUB_E,
		ST_ADD_S,
		ST_MUL_P,
		ST_MUL_AU,
		ST_MUL_Q,
		ST_DELIVER
	} state_t;

	typedef enum logic [1:0] {
		FOP_MUL,
		FOP_ADD,
		FOP_SUB
	} fop_t;

	typedef enum logic [2:0] {
		SRC_A,
		SRC_B,
		SRC_U,
		SRC_ONE,
		SRC_T,
		SRC_E,
		SRC_S,
		SRC_P
	} src_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_T,
		DST_E,
		DST_S,
		DST_P
	} dst_t;

	typedef struct packed {
		logic load_in;
		logic init;
		logic issue;
		fop_t op;
		src_t src_x;
		src_t src_y;
		logic wb;
		dst_t dst;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic fpu_done;
	} stat_t;

endpackage
`default_nettype wire

// ===== src/srd_fpu.sv =====
// Three-stage binary32 multiply / add / subtract unit, round to nearest even
`default_nettype none
module srd_fpu (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         issue,
	input  wire srd_pkg::fop_t op,
	input  wire logic [31:0]  x,
	input  wire logic [31:0]  y,
	output logic              done,
	output logic [31:0]       z
);
	import srd_pkg::*;

	// unpack
	logic        sx, sy;
	logic [7:0]  ex, ey, exe, eye;
	logic [23:0] sigx, sigy;
	logic        nanx, nany, infx, infy, zerx, zery;

	// stage 1 working values
	logic        mag_ge;
	logic        sl, ss;
	logic [7:0]  el, es, d;
	logic [23:0] sigl, sigs;
	logic [26:0] al, full, shf, lostm;
	logic        stk;
	logic [26:0] as_v;
	logic [27:0] r28;
	logic [47:0] r_c;
	logic signed [10:0] t_c;
	logic        sign_c, zsign_c, nan_c, inf_c;

	logic               v_s1;
	logic [47:0]        r_s1;
	logic signed [10:0] t_s1;
	logic               sign_s1, zsign_s1, nan_s1, inf_s1;

	// stage 2
	logic [5:0]         lz;
	logic signed [10:0] enorm, shfull;
	logic signed [10:0] e_c2;
	logic signed [6:0]  sh_c2;

	logic               v_s2;
	logic [47:0]        r_s2;
	logic signed [10:0] e_s2;
	logic signed [6:0]  sh_s2;
	logic               sign_s2, zsign_s2, nan_s2, inf_s2, zero_s2;

	// stage 3
	logic [6:0]  nsh;
	logic [97:0] vsh;
	logic [47:0] kept;
	logic        guard, sticky, up;
	logic [24:0] sig25;
	logic signed [10:0] ef;
	logic [7:0]  efield;
	logic [22:0] mant;
	logic [31:0] res_c;

	logic        v_s3;
	logic [31:0] res_s3;

	assign sx   = x[31];
	assign sy   = (op == FOP_SUB) ? ~y[31] : y[31];
	assign ex   = x[30:23];
	assign ey   = y[30:23];
	assign exe  = (ex == 8'd0) ? 8'd1 : ex;
	assign eye  = (ey == 8'd0) ? 8'd1 : ey;
	assign sigx = {ex != 8'd0, x[22:0]};
	assign sigy = {ey != 8'd0, y[22:0]};
	assign nanx = (ex == 8'hFF) && (x[22:0] != 23'd0);
	assign nany = (ey == 8'hFF) && (y[22:0] != 23'd0);
	assign infx = (ex == 8'hFF) && (x[22:0] == 23'd0);
	assign infy = (ey == 8'hFF) && (y[22:0] == 23'd0);
	assign zerx = (x[30:0] == 31'd0);
	assign zery = (y[30:0] == 31'd0);

	always_comb begin
		mag_ge = (x[30:0] >= y[30:0]);
		sl     = mag_ge ? sx : sy;
		ss     = mag_ge ? sy : sx;
		el     = mag_ge ? exe : eye;
		es     = mag_ge ? eye : exe;
		sigl   = mag_ge ? sigx : sigy;
		sigs   = mag_ge ? sigy : sigx;
		d      = el - es;
		al     = {sigl, 3'b000};
		full   = {sigs, 3'b000};
		if (d >= 8'd27) begin
			shf   = '0;
			lostm = '1;
		end else begin
			shf   = full >> d[4:0];
			lostm = (27'd1 << d[4:0]) - 27'd1;
		end
		stk  = |(full & lostm);
		as_v = {shf[26:1], shf[0] | stk};
		if (sl != ss)
			r28 = {1'b0, al} - {1'b0, as_v};
		else
			r28 = {1'b0, al} + {1'b0, as_v};

		if (op == FOP_MUL) begin
			r_c     = sigx * sigy;
			t_c     = $signed({3'b000, exe}) + $signed({3'b000, eye}) - 11'sd150;
			sign_c  = sx ^ sy;
			zsign_c = sx ^ sy;
			nan_c   = nanx || nany || (infx && zery) || (zerx && infy);
			inf_c   = infx || infy;
		end else begin
			r_c     = {20'd0, r28};
			t_c     = $signed({3'b000, el}) - 11'sd3;
			sign_c  = sl;
			zsign_c = sx & sy;
			nan_c   = nanx || nany || (infx && infy && (sx != sy));
			inf_c   = infx || infy;
			if (infx)
				sign_c = sx;
			else if (infy)
				sign_c = sy;
		end
	end

	always_ff @(posedge clk) begin
		r_s1     <= r_c;
		t_s1     <= t_c;
		sign_s1  <= sign_c;
		zsign_s1 <= zsign_c;
		nan_s1   <= nan_c;
		inf_s1   <= inf_c;
	end

	// leading one position
	always_comb begin
		lz = '0;
		for (int i = 0; i < 48; i++) begin
			if (r_s1[i])
				lz = 6'(i);
		end
		enorm = t_s1 + $signed({5'd0, lz}) - 11'sd23;
		if (enorm >= 11'sd1) begin
			shfull = $signed({5'd0, lz}) - 11'sd23;
			e_c2   = enorm;
		end else begin
			shfull = 11'sd1 - t_s1;
			e_c2   = '0;
		end
		if (shfull > 11'sd49)
			sh_c2 = 7'sd49;
		else
			sh_c2 = shfull[6:0];
	end

	always_ff @(posedge clk) begin
		r_s2     <= r_s1;
		e_s2     <= e_c2;
		sh_s2    <= sh_c2;
		sign_s2  <= sign_s1;
		zsign_s2 <= zsign_s1;
		nan_s2   <= nan_s1;
		inf_s2   <= inf_s1;
		zero_s2  <= (r_s1 == 48'd0);
	end

	// shift, round, pack
	always_comb begin
		nsh = 7'd0 - sh_s2;
		vsh = {r_s2, 50'd0} >> sh_s2[5:0];
		if (sh_s2[6]) begin
			kept   = r_s2 << nsh[4:0];
			guard  = 1'b0;
			sticky = 1'b0;
		end else begin
			kept   = vsh[97:50];
			guard  = vsh[49];
			sticky = |vsh[48:0];
		end
		up    = guard & (sticky | kept[0]);
		sig25 = {1'b0, kept[23:0]} + {24'd0, up};
		ef    = e_s2 + $signed({10'd0, sig25[24]});
		mant  = sig25[24] ? sig25[23:1] : sig25[22:0];
		if (e_s2 == 11'sd0)
			efield = {7'd0, sig25[23]};
		else
			efield = ef[7:0];

		if (nan_s2)
			res_c = CANON_NAN;
		else if (inf_s2 || (ef >= 11'sd255))
			res_c = {sign_s2, 8'hFF, 23'd0};
		else if (zero_s2)
			res_c = {zsign_s2, 31'd0};
		else
			res_c = {sign_s2, efield, mant};
	end

	always_ff @(posedge clk) begin
		res_s3 <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign done = v_s3;
	assign z    = res_s3;
endmodule
`default_nettype wire

// ===== src/srd_dp.sv =====
// Datapath: operand registers, series accumulators, float unit and output register
`default_nettype none
module srd_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire srd_pkg::cmd_t  cmd,
	input  wire logic [31:0]    dividend,
	input  wire logic [31:0]    divisor,
	input  wire logic [31:0]    recip_guess,
	output srd_pkg::stat_t      stat,
	output logic [31:0]         quotient
);
	import srd_pkg::*;

	logic [31:0] a_q, b_q, u_q, t_q, e_q, s_q, p_q, quot_q;
	logic [31:0] opx, opy, fz;
	logic        fdone;

	function automatic logic [31:0] pick(input src_t sel, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] u, input logic [31:0] t,
			input logic [31:0] e, input logic [31:0] s, input logic [31:0] p);
		logic [31:0] v;
		unique case (sel)
			SRC_A:   v = a;
			SRC_B:   v = b;
			SRC_U:   v = u;
			SRC_ONE: v = FP_ONE;
			SRC_T:   v = t;
			SRC_E:   v = e;
			SRC_S:   v = s;
			SRC_P:   v = p;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign opx = pick(cmd.src_x, a_q, b_q, u_q, t_q, e_q, s_q, p_q);
	assign opy = pick(cmd.src_y, a_q, b_q, u_q, t_q, e_q, s_q, p_q);

	srd_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (cmd.issue),
		.op     (cmd.op),
		.x      (opx),
		.y      (opy),
		.done   (fdone),
		.z      (fz)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q <= dividend;
			b_q <= divisor;
			u_q <= recip_guess;
		end
		if (cmd.init) begin
			s_q <= '0;
			p_q <= FP_ONE;
		end
		if (cmd.wb) begin
			unique case (cmd.dst)
				DST_T:    t_q <= fz;
				DST_E:    e_q <= fz;
				DST_S:    s_q <= fz;
				DST_P:    p_q <= fz;
				default: ;
			endcase
		end
		if (cmd.load_out)
			quot_q <= t_q;
	end

	assign stat.fpu_done = fdone;
	assign quotient      = quot_q;
endmodule
`default_nettype wire

// ===== src/srd_ctrl.sv =====
// Controller: sequences the float operations of one request and runs both handshakes
`default_nettype none
module srd_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       out_stall,
	input  wire logic [srd_pkg::TermW-1:0]  term_count,
	input  wire srd_pkg::stat_t             stat,
	output logic                            in_stall,
	output logic                            out_valid,
	output srd_pkg::cmd_t                   cmd
);
	import srd_pkg::*;

	state_t           state_q, state_d;
	logic             busy_q, busy_d;
	logic [TermW-1:0] cnt_q, cnt_d, nterm_q, nterm_d;
	logic             ovalid_q, ovalid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			nterm_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			busy_q   <= busy_d;
			cnt_q    <= cnt_d;
			nterm_q  <= nterm_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy_d    = busy_q;
		cnt_d     = cnt_q;
		nterm_d   = nterm_q;
		ovalid_d  = ovalid_q && out_stall;
		cmd       = '0;
		cmd.op    = FOP_MUL;
		cmd.src_x = SRC_A;
		cmd.src_y = SRC_U;
		cmd.dst   = DST_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.init    = 1'b1;
					cnt_d       = '0;
					nterm_d     = (term_count > TermW'(MaxTerms)) ?
						TermW'(MaxTerms) : term_count;
					state_d     = ST_MUL_BU;
				end
			end
			ST_MUL_BU: begin
				cmd.op = FOP_MUL; cmd.src_x = SRC_B; cmd.src_y = SRC_U; cmd.dst = DST_T;
			end
			ST_SUB_E: begin
				cmd.op = FOP_SUB; cmd.src_x = SRC_ONE; cmd.src_y = SRC_T; cmd.dst = DST_E;
			end
			ST_ADD_S: begin
				cmd.op = FOP_ADD; cmd.src_x = SRC_S; cmd.src_y = SRC_P; cmd.dst = DST_S;
			end
			ST_MUL_P: begin
				cmd.op = FOP_MUL; cmd.src_x = SRC_P; cmd.src_y = SRC_E; cmd.dst = DST_P;
			end
			ST_MUL_AU: begin
				cmd.op = FOP_MUL; cmd.src_x = SRC_A; cmd.src_y = SRC_U; cmd.dst = DST_T;
			end
			ST_MUL_Q: begin
				cmd.op = FOP_MUL; cmd.src_x = SRC_T; cmd.src_y = SRC_S; cmd.dst = DST_T;
			end
			ST_DELIVER: begin
				if (!ovalid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					ovalid_d     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// issue once, then wait for the unit and write back
		if (state_q != ST_IDLE && state_q != ST_DELIVER) begin
			if (!busy_q) begin
				cmd.issue = 1'b1;
				busy_d    = 1'b1;
			end else if (stat.fpu_done) begin
				cmd.wb = 1'b1;
				busy_d = 1'b0;
				unique case (state_q)
					ST_MUL_BU: state_d = ST_SUB_E;
					ST_SUB_E:  state_d = (nterm_q == '0) ? ST_MUL_AU : ST_ADD_S;
					ST_ADD_S:  state_d = ST_MUL_P;
					ST_MUL_P: begin
						cnt_d   = cnt_q + TermW'(1);
						state_d = (cnt_q + TermW'(1) == nterm_q) ? ST_MUL_AU : ST_ADD_S;
					end
					ST_MUL_AU: state_d = ST_MUL_Q;
					ST_MUL_Q:  state_d = ST_DELIVER;
					default:   state_d = ST_IDLE;
				endcase
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ovalid_q;
endmodule
`default_nettype wire

// ===== src/series_reciprocal_division_unit.sv =====
// Top level of the series reciprocal division unit: register port, controller, datapath
// Computes quotient = (dividend*recip_guess) * (e^0 + ... + e^(n-1)) with
// e = 1 - divisor*recip_guess, every step one binary32 operation with round to
// nearest even and subnormals kept; any NaN comes out as 0x7FC00000. n is the
// term_count register (address 0, reset 4, values above 16 act as 16, zero
// gives a zero sum). One request is worked at a time through a single shared
// three-stage float unit, 4 + 2n operations per request. The result waits in
// an output register, and the next request may be taken while it does. Write
// term_count only while idle.
`default_nettype none
`include "series_reciprocal_division_unit_macros.svh"
module series_reciprocal_division_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	input  wire logic [31:0] recip_guess,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      quotient,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import srd_pkg::*;

	logic [TermW-1:0] term_count_q;
	cmd_t             cmd;
	stat_t            stat;
	logic             reg_sel;
	logic             quot_nan;

	// register index is paddr / 4; only index 0 exists
	assign reg_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {{(32-TermW){1'b0}}, term_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			term_count_q <= TermW'(4);
		else if (psel && penable && pwrite && pready && reg_sel)
			term_count_q <= pwdata[TermW-1:0];
	end

	srd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.out_stall  (out_stall),
		.term_count (term_count_q),
		.stat       (stat),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.cmd        (cmd)
	);

	srd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.dividend    (dividend),
		.divisor     (divisor),
		.recip_guess (recip_guess),
		.stat        (stat),
		.quotient    (quotient)
	);

	assign quot_nan = (quotient[30:23] == 8'hFF) && (quotient[22:0] != 23'd0);

	// a taken request keeps the block busy
	`SRD_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)
	// the float unit only completes work while a request is in progress
	`SRD_ASSERT_IMP(a_done_while_busy, stat.fpu_done, in_stall)
	// NaN results leave in canonical form
	`SRD_ASSERT_IMP(a_nan_canonical, out_valid && quot_nan, quotient == CANON_NAN)
endmodule
`default_nettype wire

// ===== bench/series_reciprocal_division_unit_test.sv =====
// Self-checking bench for the series reciprocal division unit
`timescale 1ns / 1ps
`default_nettype none
module series_reciprocal_division_unit_test;
	import srd_pkg::*;

	// one request as it goes to the block
	typedef struct {
		logic [31:0] dvd;
		logic [31:0] dvs;
		logic [31:0] rcp;
	} div_req_t;

	localparam logic [2:0] ADDR_TERM_COUNT = 3'd0;
	localparam int SETTLE_CYCLES = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] dividend = '0;
	logic [31:0] divisor = '0;
	logic [31:0] recip_guess = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] quotient;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	series_reciprocal_division_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.dividend    (dividend),
		.divisor     (divisor),
		.recip_guess (recip_guess),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.quotient    (quotient),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// the bench's own copy of term_count, changed only alongside a register write
	logic [4:0]  terms_shadow;
	div_req_t    pending_reqs[$];
	logic [31:0] quotients_due[$];
	int          mismatches = 0;
	int          reqs_sent = 0;
	int          results_seen = 0;
	int          cycle_no = 0;
	int          phases_run;
	logic        took_req = 1'b0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------
	// binary32 arithmetic, round to nearest even, subnormals kept
	// ---------------------------------------------------------------

	// value = m * 2^ex, m nonzero; round and pack
	function automatic logic [31:0] fp_round(logic sg, int ex, logic [63:0] m);
		int          be;
		int          sh;
		logic [23:0] keep;
		logic        grd;
		logic        sticky;
		logic [24:0] r;
		while (!m[63]) begin
			m = m << 1;
			ex = ex - 1;
		end
		be = ex + 63 + 127;
		if (be < 1) begin
			// below the normal range: denormalise with a sticky bit
			sh = 1 - be;
			if (sh > 63)
				m = 64'd1;
			else
				m = (m >> sh) | {63'd0, (m & ((64'd1 << sh) - 64'd1)) != 64'd0};
			be = 0;
		end
		keep   = m[63:40];
		grd    = m[39];
		sticky = |m[38:0];
		r      = {1'b0, keep} + {24'd0, grd && (sticky || keep[0])};
		if (r[24]) begin
			r  = r >> 1;
			be = be + 1;
		end
		// a subnormal rounded up into the smallest normal
		if (be == 0 && r[23])
			be = 1;
		if (be >= 255)
			return {sg, 8'hFF, 23'd0};
		return {sg, be[7:0], r[22:0]};
	endfunction

	function automatic logic is_nan(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 23'd0;
	endfunction

	function automatic logic is_inf(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] == 23'd0;
	endfunction

	function automatic logic is_zero(logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	function automatic logic [31:0] fp_mul(logic [31:0] x, logic [31:0] y);
		logic        sg;
		logic [63:0] mx;
		logic [63:0] my;
		int          ex;
		int          ey;
		sg = x[31] ^ y[31];
		if (is_nan(x) || is_nan(y))
			return CANON_NAN;
		if ((is_inf(x) && is_zero(y)) || (is_zero(x) && is_inf(y)))
			return CANON_NAN;
		if (is_inf(x) || is_inf(y))
			return {sg, 8'hFF, 23'd0};
		if (is_zero(x) || is_zero(y))
			return {sg, 31'd0};
		mx = {40'd0, x[30:23] != 8'd0, x[22:0]};
		my = {40'd0, y[30:23] != 8'd0, y[22:0]};
		ex = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
		ey = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
		return fp_round(sg, ex + ey - 300, mx * my);
	endfunction

	function automatic logic [31:0] fp_add(logic [31:0] x, logic [31:0] y);
		logic [31:0] big;
		logic [31:0] lit;
		logic [63:0] mb;
		logic [63:0] ml;
		logic [63:0] sum;
		logic        sg;
		int          eb;
		int          el;
		int          d;
		if (is_nan(x) || is_nan(y))
			return CANON_NAN;
		if (is_inf(x) && is_inf(y))
			return (x[31] == y[31]) ? x : CANON_NAN;
		if (is_inf(x))
			return x;
		if (is_inf(y))
			return y;
		if (is_zero(x) && is_zero(y))
			return {x[31] & y[31], 31'd0};
		if (is_zero(x))
			return y;
		if (is_zero(y))
			return x;
		// order by magnitude so the difference stays positive
		if (x[30:0] >= y[30:0]) begin
			big = x;
			lit = y;
		end else begin
			big = y;
			lit = x;
		end
		eb = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
		el = (lit[30:23] == 8'd0) ? 1 : int'(lit[30:23]);
		mb = {40'd0, big[30:23] != 8'd0, big[22:0]} << 38;
		ml = {40'd0, lit[30:23] != 8'd0, lit[22:0]} << 38;
		d  = eb - el;
		if (d > 63)
			ml = 64'd1;
		else if (d > 0)
			ml = (ml >> d) | {63'd0, (ml & ((64'd1 << d) - 64'd1)) != 64'd0};
		sg  = big[31];
		sum = (big[31] == lit[31]) ? mb + ml : mb - ml;
		if (sum == 64'd0)
			return 32'd0;
		return fp_round(sg, eb - 188, sum);
	endfunction

	// quotient the block should give for one request at the current term count
	function automatic logic [31:0] series_quotient(div_req_t rq);
		logic [31:0] err;
		logic [31:0] acc;
		logic [31:0] pw;
		logic [31:0] q;
		int          n;
		n   = (terms_shadow > MaxTerms) ? MaxTerms : int'(terms_shadow);
		err = fp_add(FP_ONE, fp_mul(rq.dvs, rq.rcp) ^ 32'h8000_0000);
		acc = 32'd0;
		pw  = FP_ONE;
		for (int i = 0; i < n; i++) begin
			acc = fp_add(acc, pw);
			pw  = fp_mul(pw, err);
		end
		q = fp_mul(fp_mul(rq.dvd, rq.rcp), acc);
		return is_nan(q) ? CANON_NAN : q;
	endfunction

	// ---------------------------------------------------------------
	// idling: roughly 30 in 100 calls, none inside a quiet window
	// ---------------------------------------------------------------
	function automatic logic want_idle();
		if (cycle_no >= 4000 && cycle_no < 12000)
			return 1'b0;
		return $urandom_range(99) < 30;
	endfunction

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	// request side: acceptance is seen at the rising edge, prediction made here
	always @(posedge clk) begin
		took_req = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			quotients_due.push_back(series_quotient(pending_reqs[0]));
			void'(pending_reqs.pop_front());
			reqs_sent++;
			took_req = 1'b1;
		end
	end

	// driver: a valid request stays up, unchanged, until taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took_req)) begin
			if (pending_reqs.size() > 0 && !want_idle()) begin
				in_valid    <= 1'b1;
				dividend    <= pending_reqs[0].dvd;
				divisor     <= pending_reqs[0].dvs;
				recip_guess <= pending_reqs[0].rcp;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n ? want_idle() : 1'b0;
	end

	// result side: compare against the oldest outstanding quotient
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (quotients_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected quotient %h", quotient);
			end else begin
				if (quotient !== quotients_due[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("quotient mismatch: exp %h got %h",
							quotients_due[0], quotient);
				end
				void'(quotients_due.pop_front());
			end
		end
	end

	// register write over the APB-style port: setup then access
	task automatic write_terms(logic [4:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_TERM_COUNT;
		pwdata  <= {27'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		terms_shadow = val;
	endtask

	// wait until the block has drained, then let any tail settle
	task automatic drain();
		wait (pending_reqs.size() == 0 && quotients_due.size() == 0 && !in_valid);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic div_req_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] u);
		div_req_t r;
		r.dvd = a;
		r.dvs = b;
		r.rcp = u;
		return r;
	endfunction

	// mostly a divisor with a rough reciprocal, sometimes raw bits
	task automatic queue_random(int count);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] u;
		logic [7:0]  be;
		for (int k = 0; k < count; k++) begin
			a = $urandom();
			if ($urandom_range(99) < 70) begin
				be = 8'($urandom_range(30, 224));
				b  = {1'($urandom_range(1)), be, 23'($urandom())};
				// 1/(1.f) is near (3 - 1.f)/2: complement the fraction
				u  = {b[31], 8'(253) - be, ~b[22:0] ^ 23'($urandom_range(255))};
				if (b[22:0] == 23'd0)
					u = {b[31], 8'(254) - be, 23'($urandom_range(15))};
				if ($urandom_range(3) == 0)
					a = {a[31], 8'($urandom_range(100, 160)), a[22:0]};
			end else begin
				b = $urandom();
				u = $urandom();
			end
			pending_reqs.push_back(mk(a, b, u));
		end
	endtask

	initial begin
		logic [4:0] plan[6];
		plan = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd2, 5'd9};
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		terms_shadow = 5'd4;
		phases_run   = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset term count, special operands
		pending_reqs.push_back(mk(32'h3F80_0000, 32'h4000_0000, 32'h3F00_0000)); // exact
		pending_reqs.push_back(mk(32'h4040_0000, 32'h4040_0000, 32'h3EAA_AAAB));
		pending_reqs.push_back(mk(32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000)); // +0
		pending_reqs.push_back(mk(32'h8000_0000, 32'h3F80_0000, 32'h3F80_0000)); // -0
		pending_reqs.push_back(mk(32'h7F80_0000, 32'h4000_0000, 32'h3F00_0000)); // inf
		pending_reqs.push_back(mk(32'h7F80_0000, 32'h4000_0000, 32'h0000_0000)); // inf*0
		pending_reqs.push_back(mk(32'h7FC1_2345, 32'h3F80_0000, 32'h3F80_0000)); // NaN
		pending_reqs.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(32'h3F80_0000, 32'h0000_0000, 32'h7F80_0000)); // 0*inf
		pending_reqs.push_back(mk(32'h3F80_0000, 32'h7F7F_FFFF, 32'h7F7F_FFFF)); // overflow
		pending_reqs.push_back(mk(32'h0000_0001, 32'h3F80_0000, 32'h3F80_0000)); // denormal
		pending_reqs.push_back(mk(32'h0080_0000, 32'h4000_0000, 32'h3F00_0000));
		pending_reqs.push_back(mk(32'h3F80_0000, 32'h3FC0_0000, 32'h3F00_0000)); // 0<e<1
		pending_reqs.push_back(mk(32'hC2C8_0000, 32'hC0A0_0000, 32'hBE4C_CCCD));
		pending_reqs.push_back(mk(32'h7F7F_FFFF, 32'h0000_0001, 32'h7F7F_FFFF));
		pending_reqs.push_back(mk(32'h3F80_0000, 32'h4000_0000, 32'h4000_0000)); // |e|>1
		pending_reqs.push_back(mk(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
		pending_reqs.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		queue_random(60);
		drain();
		phases_run++;

		// several term counts, extremes and saturation among them; the
		// sender holds back between phases until all quotients are in
		foreach (plan[i]) begin
			write_terms(plan[i]);
			if (plan[i] == 5'd0) begin
				pending_reqs.push_back(mk(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000));
				pending_reqs.push_back(mk(32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000));
			end
			queue_random((plan[i] >= 5'd16) ? 60 : 80);
			drain();
			phases_run++;
		end
		write_terms(5'd4);
		queue_random(20);
		drain();
		phases_run++;

		$display("%0d requests over %0d term-count phases, %0d quotients checked",
			reqs_sent, phases_run, results_seen);
		$display("term counts 0, 1, 2, 4, 9, 16 and 31 covered, with stalls both ways");
		if (mismatches == 0 && quotients_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d quotients outstanding",
				mismatches, quotients_due.size());
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#20ms;
		$display("timeout with %0d quotients outstanding", quotients_due.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/srd_pkg.sv
src/srd_fpu.sv
src/srd_dp.sv
src/srd_ctrl.sv
src/series_reciprocal_division_unit.sv
bench/series_reciprocal_division_unit_test.sv
